// File: rtl/core/ata_pkg.sv
// shared types, constants and the arctangent table for the tilt angle block
// no dependencies
package ata_pkg;

	localparam int WINDOW_DEPTH_DEF = 10;
	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int FIELD_W          = 16;
	localparam int ANGLE_W          = 16;
	localparam int CORDIC_ITERS     = 24;
	localparam int ITER_W           = 5;
	localparam int FRAC_SHIFT       = 16;
	localparam int ROUND_SHIFT      = 17;
	localparam int Z_W              = 33;
	localparam int HALF_PI_Q13      = 12868;
	localparam int QUEUE_DEPTH      = 2;

	typedef struct packed {
		logic signed [FIELD_W-1:0] accel_x;
		logic signed [FIELD_W-1:0] accel_y;
		logic signed [FIELD_W-1:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll_now;
		logic signed [ANGLE_W-1:0] pitch_now;
		logic signed [ANGLE_W-1:0] roll_smoothed;
		logic signed [ANGLE_W-1:0] pitch_smoothed;
	} angles_t;

	typedef struct packed {
		logic idle;
		logic done;
	} tilt_status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_READ,
		F_UPDATE
	} front_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_SQUARE,
		T_SUM,
		T_ROOT,
		T_INIT,
		T_ROTATE,
		T_DONE
	} tilt_state_t;

	// atan(2^-i) in Q2.30, truncated
	function automatic logic [31:0] atan_q30(input logic [ITER_W-1:0] idx);
		logic [31:0] t;
		case (idx)
			5'd0: t = 32'h3243F6A8;
			5'd1: t = 32'h1DAC6705;
			5'd2: t = 32'h0FADBAFC;
			5'd3: t = 32'h07F56EA6;
			5'd4: t = 32'h03FEAB76;
			5'd5: t = 32'h01FFD55B;
			5'd6: t = 32'h00FFFAAA;
			5'd7: t = 32'h007FFF55;
			5'd8: t = 32'h003FFFEA;
			5'd9: t = 32'h001FFFFD;
			5'd10: t = 32'h000FFFFF;
			5'd11: t = 32'h0007FFFF;
			5'd12: t = 32'h0003FFFF;
			5'd13: t = 32'h0001FFFF;
			5'd14: t = 32'h0000FFFF;
			5'd15: t = 32'h00007FFF;
			5'd16: t = 32'h00003FFF;
			5'd17: t = 32'h00001FFF;
			5'd18: t = 32'h00000FFF;
			5'd19: t = 32'h000007FF;
			5'd20: t = 32'h000003FF;
			5'd21: t = 32'h000001FF;
			5'd22: t = 32'h000000FF;
			5'd23: t = 32'h0000007F;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

endpackage

// File: rtl/core/ata_ram.sv
// generic single write port ram with registered read
// no dependencies
module ata_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/ata_fifo.sv
// short queue between the window front end and the angle back end
// no dependencies
module ata_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/ata_front.sv
// front end: takes sample beats, updates the moving windows and running sums
// depends on ata_pkg, ata_ram
module ata_front #(
	parameter int WINDOW_DEPTH = ata_pkg::WINDOW_DEPTH_DEF,
	parameter int SAMPLE_BITS  = ata_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W        = SAMPLE_BITS + $clog2(WINDOW_DEPTH),
	parameter int ENTRY_W      = 3 * SAMPLE_BITS + 3 * SUM_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  ata_pkg::sample_t    sample,
	output logic                push,
	output logic [ENTRY_W-1:0]  push_data,
	input  logic                full
);

	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int HIST_W = 3 * SAMPLE_BITS;

	ata_pkg::front_state_t state_q, state_d;

	logic [SLOT_W-1:0]             slot_q;
	logic [WINDOW_DEPTH-1:0]       valid_q;
	logic signed [SAMPLE_BITS-1:0] x_q, y_q, z_q;
	logic signed [SAMPLE_BITS-1:0] x_in, y_in, z_in;
	logic signed [SAMPLE_BITS-1:0] ox, oy, oz;
	logic signed [SUM_W-1:0]       sum_x_q, sum_y_q, sum_z_q;
	logic signed [SUM_W-1:0]       sum_x_d, sum_y_d, sum_z_d;
	logic [HIST_W-1:0]             rdata;
	logic [HIST_W-1:0]             old_hist;
	logic                          accept;
	logic                          update;

	generate
		if (SAMPLE_BITS <= ata_pkg::FIELD_W) begin : g_narrow
			assign x_in = sample.accel_x[SAMPLE_BITS-1:0];
			assign y_in = sample.accel_y[SAMPLE_BITS-1:0];
			assign z_in = sample.accel_z[SAMPLE_BITS-1:0];
		end else begin : g_wide
			assign x_in = {{(SAMPLE_BITS - ata_pkg::FIELD_W){1'b0}}, sample.accel_x};
			assign y_in = {{(SAMPLE_BITS - ata_pkg::FIELD_W){1'b0}}, sample.accel_y};
			assign z_in = {{(SAMPLE_BITS - ata_pkg::FIELD_W){1'b0}}, sample.accel_z};
		end
	endgenerate

	ata_ram #(
		.WIDTH(HIST_W),
		.DEPTH(WINDOW_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (update),
		.waddr(slot_q),
		.wdata({x_q, y_q, z_q}),
		.raddr(slot_q),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ata_pkg::F_IDLE:   if (accept) state_d = ata_pkg::F_READ;
			ata_pkg::F_READ:   state_d = ata_pkg::F_UPDATE;
			ata_pkg::F_UPDATE: state_d = ata_pkg::F_IDLE;
			default:           state_d = ata_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		sample_ready = (state_q == ata_pkg::F_IDLE) && !full;
		update       = (state_q == ata_pkg::F_UPDATE);
	end

	assign accept   = sample_valid && sample_ready;
	// slot never written since reset reads as zero
	assign old_hist = valid_q[slot_q] ? rdata : '0;
	assign ox       = old_hist[HIST_W-1 -: SAMPLE_BITS];
	assign oy       = old_hist[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
	assign oz       = old_hist[SAMPLE_BITS-1:0];
	assign sum_x_d  = sum_x_q + SUM_W'(x_q) - SUM_W'(ox);
	assign sum_y_d  = sum_y_q + SUM_W'(y_q) - SUM_W'(oy);
	assign sum_z_d  = sum_z_q + SUM_W'(z_q) - SUM_W'(oz);
	assign push      = update;
	assign push_data = {x_q, y_q, z_q, sum_x_d, sum_y_d, sum_z_d};

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= z_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ata_pkg::F_IDLE;
			slot_q  <= '0;
			valid_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else begin
			state_q <= state_d;
			if (update) begin
				sum_x_q         <= sum_x_d;
				sum_y_q         <= sum_y_d;
				sum_z_q         <= sum_z_d;
				valid_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/ata_tilt.sv
// one tilt lane: atan2(a, sqrt(b^2 + c^2)) by digit square root and cordic
// depends on ata_pkg
module ata_tilt #(
	parameter int AW = 21
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [AW-1:0]              a,
	input  logic signed [AW-1:0]              b,
	input  logic signed [AW-1:0]              c,
	input  logic                              ack,
	output ata_pkg::tilt_status_t             status,
	output logic signed [ata_pkg::ANGLE_W-1:0] angle
);

	localparam int NW    = 2 * AW;
	localparam int RW    = AW;
	localparam int CNT_W = $clog2(AW + 1);
	localparam int CW    = AW + ata_pkg::FRAC_SHIFT + 3;
	localparam int ZW    = ata_pkg::Z_W;

	ata_pkg::tilt_state_t state_q, state_d;

	logic signed [AW-1:0]     a_q;
	logic [AW-1:0]            ub_q, uc_q;
	logic [NW-1:0]            bsq_q, csq_q, n_q;
	logic [RW-1:0]            root_q;
	logic [RW+1:0]            rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [CW-1:0]     x_q, y_q;
	logic signed [ZW-1:0]     z_q;
	logic [ata_pkg::ITER_W-1:0] iter_q;
	logic                     zero_q;

	logic [RW+3:0]            shifted, trial, diff;
	logic                     ge;
	logic signed [CW-1:0]     xs, ys;
	logic signed [ZW-1:0]     t;
	logic [ZW-1:0]            zabs, mag;
	logic [ata_pkg::ANGLE_W-1:0] mag16;
	logic                     last_root, last_iter;

	assign shifted = {rem_q, n_q[NW-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign diff    = shifted - trial;
	assign ge      = (shifted >= trial);
	assign xs      = x_q >>> iter_q;
	assign ys      = y_q >>> iter_q;
	assign t       = $signed({1'b0, ata_pkg::atan_q30(iter_q)});
	assign last_root = (cnt_q == CNT_W'(AW - 1));
	assign last_iter = (iter_q == ata_pkg::ITER_W'(ata_pkg::CORDIC_ITERS - 1));

	// round half away from zero to q13, clamp to +-pi/2
	assign zabs  = z_q[ZW-1] ? ZW'(-z_q) : ZW'(z_q);
	assign mag   = (zabs + ZW'(1 << (ata_pkg::ROUND_SHIFT - 1))) >> ata_pkg::ROUND_SHIFT;
	assign mag16 = (mag > ZW'(ata_pkg::HALF_PI_Q13)) ?
		ata_pkg::ANGLE_W'(ata_pkg::HALF_PI_Q13) : mag[ata_pkg::ANGLE_W-1:0];
	assign angle = zero_q ? '0 : (z_q[ZW-1] ? -$signed(mag16) : $signed(mag16));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ata_pkg::T_IDLE:   if (start) state_d = ata_pkg::T_SQUARE;
			ata_pkg::T_SQUARE: state_d = ata_pkg::T_SUM;
			ata_pkg::T_SUM:    state_d = ata_pkg::T_ROOT;
			ata_pkg::T_ROOT:   if (last_root) state_d = ata_pkg::T_INIT;
			ata_pkg::T_INIT:   state_d = ata_pkg::T_ROTATE;
			ata_pkg::T_ROTATE: if (last_iter) state_d = ata_pkg::T_DONE;
			ata_pkg::T_DONE:   if (ack) state_d = ata_pkg::T_IDLE;
			default:           state_d = ata_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		status.idle = (state_q == ata_pkg::T_IDLE);
		status.done = (state_q == ata_pkg::T_DONE);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ata_pkg::T_IDLE: begin
				a_q    <= a;
				ub_q   <= b[AW-1] ? (~b + 1'b1) : b;
				uc_q   <= c[AW-1] ? (~c + 1'b1) : c;
				zero_q <= (a == '0);
			end
			ata_pkg::T_SQUARE: begin
				bsq_q <= NW'(ub_q) * NW'(ub_q);
				csq_q <= NW'(uc_q) * NW'(uc_q);
			end
			ata_pkg::T_SUM: begin
				n_q    <= bsq_q + csq_q;
				root_q <= '0;
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			ata_pkg::T_ROOT: begin
				n_q    <= n_q << 2;
				rem_q  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
				root_q <= {root_q[RW-2:0], ge};
				cnt_q  <= cnt_q + 1'b1;
			end
			ata_pkg::T_INIT: begin
				x_q    <= $signed({{(CW - RW - ata_pkg::FRAC_SHIFT){1'b0}}, root_q,
					{ata_pkg::FRAC_SHIFT{1'b0}}});
				y_q    <= {{(CW - AW - ata_pkg::FRAC_SHIFT){a_q[AW-1]}}, a_q,
					{ata_pkg::FRAC_SHIFT{1'b0}}};
				z_q    <= '0;
				iter_q <= '0;
			end
			ata_pkg::T_ROTATE: begin
				if (!y_q[CW-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + t;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - t;
				end
				iter_q <= iter_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ata_pkg::T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/ata_back.sv
// back end: four tilt lanes in parallel and the result output register
// depends on ata_pkg, ata_tilt
module ata_back #(
	parameter int SAMPLE_BITS = ata_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W       = ata_pkg::SAMPLE_BITS_DEF + $clog2(ata_pkg::WINDOW_DEPTH_DEF),
	parameter int ENTRY_W     = 3 * SAMPLE_BITS + 3 * SUM_W
) (
	input  logic               clk,
	input  logic               arst_n,
	output logic               pop,
	input  logic [ENTRY_W-1:0] pop_data,
	input  logic               empty,
	output logic               angle_valid,
	input  logic               angle_ready,
	output ata_pkg::angles_t   angles
);

	localparam int AW = SUM_W + 1;

	logic signed [SAMPLE_BITS-1:0] x, y, z;
	logic signed [SUM_W-1:0]       sx, sy, sz;
	logic signed [AW-1:0]          xe, ye, ze, sxe, sye, sze;
	ata_pkg::tilt_status_t         st0, st1, st2, st3;
	logic signed [ata_pkg::ANGLE_W-1:0] ang0, ang1, ang2, ang3;
	logic                          all_idle, all_done, ack;
	logic                          valid_q;
	ata_pkg::angles_t              angles_q;

	assign {x, y, z, sx, sy, sz} = pop_data;
	assign xe  = AW'(x);
	assign ye  = AW'(y);
	assign ze  = AW'(z);
	assign sxe = AW'(sx);
	assign sye = AW'(sy);
	assign sze = AW'(sz);

	assign all_idle = st0.idle && st1.idle && st2.idle && st3.idle;
	assign all_done = st0.done && st1.done && st2.done && st3.done;
	assign pop      = all_idle && !empty;
	assign ack      = all_done && (!valid_q || angle_ready);

	ata_tilt #(.AW(AW)) u_roll_now (
		.clk(clk), .arst_n(arst_n), .start(pop), .a(ye), .b(xe), .c(ze),
		.ack(ack), .status(st0), .angle(ang0)
	);

	ata_tilt #(.AW(AW)) u_pitch_now (
		.clk(clk), .arst_n(arst_n), .start(pop), .a(-xe), .b(ye), .c(ze),
		.ack(ack), .status(st1), .angle(ang1)
	);

	ata_tilt #(.AW(AW)) u_roll_avg (
		.clk(clk), .arst_n(arst_n), .start(pop), .a(sye), .b(sxe), .c(sze),
		.ack(ack), .status(st2), .angle(ang2)
	);

	ata_tilt #(.AW(AW)) u_pitch_avg (
		.clk(clk), .arst_n(arst_n), .start(pop), .a(-sxe), .b(sye), .c(sze),
		.ack(ack), .status(st3), .angle(ang3)
	);

	assign angle_valid = valid_q;
	assign angles      = angles_q;

	always_ff @(posedge clk) begin
		if (ack) begin
			angles_q.roll_now       <= ang0;
			angles_q.pitch_now      <= ang1;
			angles_q.roll_smoothed  <= ang2;
			angles_q.pitch_smoothed <= ang3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ack) begin
			valid_q <= 1'b1;
		end else if (angle_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/accel_tilt_angles_averaged.sv
// top level of the accelerometer tilt angle block: front end, queue, back end
// depends on ata_pkg, ata_front, ata_fifo, ata_back
//
//   channel  | signals                             | beat
//   sample   | sample_valid, sample_ready, sample  | one x/y/z accelerometer sample
//   angle    | angle_valid, angle_ready, angles    | roll/pitch now and smoothed, q3.13
//
// front end steps per sample: take, history read, update with queue push
// each angle goes through squares, digit square root and 24 cordic passes in its lane;
// the four lanes run together
// the lanes take the next queued sample in the idle state after the result register loads
// a new sample is taken while the back end works, up to two wait in the queue
// reset clears the windows through per-slot valid bits, no clearing pass
module accel_tilt_angles_averaged #(
	parameter int WINDOW_DEPTH = ata_pkg::WINDOW_DEPTH_DEF,
	parameter int SAMPLE_BITS  = ata_pkg::SAMPLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  ata_pkg::sample_t sample,
	output logic             angle_valid,
	input  logic             angle_ready,
	output ata_pkg::angles_t angles
);

	localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
	localparam int ENTRY_W = 3 * SAMPLE_BITS + 3 * SUM_W;

	logic               push, pop, full, empty;
	logic [ENTRY_W-1:0] push_data, pop_data;

	ata_front #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_W       (SUM_W),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	ata_fifo #(
		.WIDTH(ENTRY_W),
		.DEPTH(ata_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	ata_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_W      (SUM_W),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop        (pop),
		.pop_data   (pop_data),
		.empty      (empty),
		.angle_valid(angle_valid),
		.angle_ready(angle_ready),
		.angles     (angles)
	);

endmodule

// File: rtl/core/ata_checker.sv
// port level checks for the tilt angle block, bound to the top level
// depends on ata_pkg, accel_tilt_angles_averaged
module ata_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_ready,
	input logic             angle_valid,
	input logic             angle_ready,
	input ata_pkg::angles_t angles
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && !angle_ready |=> angle_valid && $stable(angles))
		else $error("result beat changed while stalled");

	// the front end is busy right after it takes a beat
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken on back to back cycles");

	// roll_now and pitch_smoothed stay within +-pi/2
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid |->
			angles.roll_now <= ata_pkg::HALF_PI_Q13 &&
			angles.roll_now >= -ata_pkg::HALF_PI_Q13 &&
			angles.pitch_smoothed <= ata_pkg::HALF_PI_Q13 &&
			angles.pitch_smoothed >= -ata_pkg::HALF_PI_Q13)
		else $error("angle out of range");

	// no result during reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !angle_valid)
		else $error("result valid in reset");

endmodule

bind accel_tilt_angles_averaged ata_checker u_ata_checker (.*);
